>>> sv/assert_macros.svh
// Assertion macros shared by the slot allocator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CSA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// A condition that implies another one at the same edge.
`define CSA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another one at the next edge.
`define CSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/csa_pkg.sv
// Shared types and constants of the coroutine slot allocator.
// Depends on nothing; imported by the slot table, the top level and the testbench.
package csa_pkg;

    // Widths of the request and result fields.
    localparam int OP_W       = 2;
    localparam int TGT_W      = 4;
    localparam int RES_SLOT_W = 4;
    localparam int LIVE_W     = 5;
    localparam int ST_W       = 2;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    // Operation codes.
    localparam t_op OP_CREATE = 2'd0;
    localparam t_op OP_DONE   = 2'd1;
    localparam t_op OP_YIELD  = 2'd2;
    localparam t_op OP_RESUME = 2'd3;

    // Slot status codes.
    localparam t_status ST_UNUSED    = 2'd0;
    localparam t_status ST_SUSPENDED = 2'd1;
    localparam t_status ST_RUNNING   = 2'd2;
    localparam t_status ST_DONE      = 2'd3;

endpackage

>>> sv/coroutine_slot_allocator_top.sv
// Coroutine slot allocator: a free-list allocator over a table of task slots.
// The accepting edge reads the slot table into its read register; the next edge
// writes the entry back and loads the result register.
// No request is taken while the last one is in execute, so each request's read
// follows the last one's write-back; a stalled result holds off the next request.
// Reset (synchronous, active low) clears the free list, counters and current
// slot at once; the slot table needs no clearing pass.
module coroutine_slot_allocator_top
    import csa_pkg::*;
#(
    parameter int MAX_SLOTS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [TGT_W-1:0]      i_target_slot,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_ok,
    output logic [RES_SLOT_W-1:0] o_result_slot,
    output logic [LIVE_W-1:0]     o_live_count
);

    `include "assert_macros.svh"

    localparam int SLOT_W  = $clog2(MAX_SLOTS);
    localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
    localparam int DATA_W  = ST_W + SLOT_W;
    localparam int TEXT_W  = (SLOT_W > TGT_W) ? SLOT_W : TGT_W;
    localparam int CMP_W   = (CNT_W > TGT_W) ? CNT_W : TGT_W;
    localparam int SEXT_W  = (SLOT_W > RES_SLOT_W) ? SLOT_W : RES_SLOT_W;
    localparam int LEXT_W  = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;

    // Control and bookkeeping registers.
    logic              r_busy;
    t_op               r_op;
    logic [TGT_W-1:0]  r_tgt;
    logic              r_free_valid, n_free_valid;
    logic [SLOT_W-1:0] r_free_head, n_free_head;
    logic [CNT_W-1:0]  r_slots_used, n_slots_used;
    logic              r_cur_valid, n_cur_valid;
    logic [SLOT_W-1:0] r_cur_slot, n_cur_slot;
    logic [CNT_W-1:0]  r_live, n_live;

    // Result register.
    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [RES_SLOT_W-1:0] r_out_slot;
    logic [LIVE_W-1:0]     r_out_live;

    // Table ports.
    logic              in_acc;
    logic [SLOT_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    t_status           rd_status;
    logic [SLOT_W-1:0] rd_link;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    // Execute-stage results.
    logic              ex_ok;
    logic [SLOT_W-1:0] ex_slot;
    logic [TEXT_W-1:0] tgt_ext;
    logic [TEXT_W-1:0] held_tgt_ext;
    logic              tgt_in_range;
    logic [SEXT_W-1:0] slot_ext;
    logic [LEXT_W-1:0] live_ext;

    // A request enters only when the table is free and the result register
    // will be empty by the time this request completes.
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Read address: the entry the operation will modify; a create reads the free-list head.
    assign tgt_ext = TEXT_W'(i_target_slot);
    always_comb begin
        unique case (i_op)
            OP_CREATE: rd_addr = r_free_head;
            OP_DONE:   rd_addr = r_cur_slot;
            OP_YIELD:  rd_addr = r_cur_slot;
            OP_RESUME: rd_addr = tgt_ext[SLOT_W-1:0];
            default:   rd_addr = r_cur_slot;
        endcase
    end

    csa_table #(
        .DEPTH  (MAX_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // The execute stage works from the target captured with the request.
    assign held_tgt_ext = TEXT_W'(r_tgt);
    assign rd_status    = rd_data[DATA_W-1 -: ST_W];
    assign rd_link      = rd_data[SLOT_W-1:0];
    assign tgt_in_range = CMP_W'(r_tgt) < CMP_W'(r_slots_used);

    // Execute: modify the entry read last cycle and update the bookkeeping.
    always_comb begin
        n_free_valid = r_free_valid;
        n_free_head  = r_free_head;
        n_slots_used = r_slots_used;
        n_cur_valid  = r_cur_valid;
        n_cur_slot   = r_cur_slot;
        n_live       = r_live;
        ex_ok        = 1'b0;
        ex_slot      = '0;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;
        if (r_busy) begin
            unique case (r_op)
                OP_CREATE: begin
                    if (r_free_valid) begin
                        // Reuse the head of the free list; a self link ends it.
                        ex_ok   = 1'b1;
                        ex_slot = r_free_head;
                        if (rd_link == r_free_head) begin
                            n_free_valid = 1'b0;
                        end else begin
                            n_free_head = rd_link;
                        end
                    end else if (r_slots_used < CNT_W'(MAX_SLOTS)) begin
                        // Take a fresh slot.
                        ex_ok        = 1'b1;
                        ex_slot      = r_slots_used[SLOT_W-1:0];
                        n_slots_used = r_slots_used + 1'b1;
                    end
                    if (ex_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = ex_slot;
                        wr_data = {ST_SUSPENDED, ex_slot};
                        n_live  = r_live + 1'b1;
                    end
                end
                OP_DONE: begin
                    if (r_cur_valid) begin
                        // Push the current slot onto the free list.
                        ex_ok        = 1'b1;
                        ex_slot      = r_cur_slot;
                        wr_en        = 1'b1;
                        wr_addr      = r_cur_slot;
                        wr_data      = {ST_DONE, r_free_valid ? r_free_head : r_cur_slot};
                        n_free_head  = r_cur_slot;
                        n_free_valid = 1'b1;
                        n_cur_valid  = 1'b0;
                        n_cur_slot   = '0;
                        n_live       = (r_live != '0) ? r_live - 1'b1 : r_live;
                    end
                end
                OP_YIELD: begin
                    if (r_cur_valid) begin
                        ex_ok       = 1'b1;
                        ex_slot     = r_cur_slot;
                        wr_en       = 1'b1;
                        wr_addr     = r_cur_slot;
                        wr_data     = {ST_SUSPENDED, rd_link};
                        n_cur_valid = 1'b0;
                        n_cur_slot  = '0;
                    end
                end
                OP_RESUME: begin
                    if (tgt_in_range && rd_status == ST_SUSPENDED) begin
                        ex_ok       = 1'b1;
                        ex_slot     = held_tgt_ext[SLOT_W-1:0];
                        wr_en       = 1'b1;
                        wr_addr     = ex_slot;
                        wr_data     = {ST_RUNNING, rd_link};
                        n_cur_valid = 1'b1;
                        n_cur_slot  = ex_slot;
                    end
                end
                default: begin
                    ex_ok = 1'b0;
                end
            endcase
        end
    end

    // Widen the execute results to the output field widths.
    assign slot_ext = SEXT_W'(ex_slot);
    assign live_ext = LEXT_W'(n_live);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_free_valid <= 1'b0;
            r_free_head  <= '0;
            r_slots_used <= '0;
            r_cur_valid  <= 1'b0;
            r_cur_slot   <= '0;
            r_live       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= in_acc;
            r_free_valid <= n_free_valid;
            r_free_head  <= n_free_head;
            r_slots_used <= n_slots_used;
            r_cur_valid  <= n_cur_valid;
            r_cur_slot   <= n_cur_slot;
            r_live       <= n_live;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= t_op'(i_op);
            r_tgt <= i_target_slot;
        end
        if (r_busy) begin
            r_out_ok   <= ex_ok;
            r_out_slot <= slot_ext[RES_SLOT_W-1:0];
            r_out_live <= live_ext[LIVE_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_out_ok;
    assign o_result_slot = r_out_slot;
    assign o_live_count  = r_out_live;

    // Every request in execute leaves a result in the output register.
    `CSA_ASSERT_NEXT(a_exec_loads_result, i_clk, i_rst_n, r_busy, r_out_valid, "result lost")
    // A stalled result is never overwritten by a request in execute.
    `CSA_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall, !r_busy, "result overwritten")
    // Live slots never outnumber the slots ever taken.
    `CSA_ASSERT_ALWAYS(a_live_bound, i_clk, i_rst_n, r_live <= r_slots_used, "live count exceeds slots used")
    // A non-empty free list implies some slot was taken.
    `CSA_ASSERT_IMPL(a_free_needs_used, i_clk, i_rst_n, r_free_valid, r_slots_used != '0, "free list without slots")

endmodule

>>> sv/csa_table.sv
// Slot table memory: one entry per slot holding status and free-list link.
// Single write port, single read port with a registered read.
// Depends on csa_pkg for the status width.
module csa_table
    import csa_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output logic [ST_W+ADDR_W-1:0] o_rd_data,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  logic [ST_W+ADDR_W-1:0] i_wr_data
);

    logic [ST_W+ADDR_W-1:0] r_mem [DEPTH];
    logic [ST_W+ADDR_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> tb/sv/tb_coroutine_slot_allocator_top.sv
// Self-checking testbench for coroutine_slot_allocator_top: directed and random requests,
// with a scoreboard class that models the slot table and checks every result in order.
// Depends on csa_pkg and the allocator RTL.
module tb_coroutine_slot_allocator_top;
    import csa_pkg::*;

    localparam int NSLOT        = 16;
    localparam int PHASE_COUNT  = 13;
    localparam int PHASE_ITEMS  = 125;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_GAP      = 18;

    typedef struct {
        logic                  ok;
        logic [RES_SLOT_W-1:0] slot;
        logic [LIVE_W-1:0]     live;
    } t_outcome;

    // Slot table model and the queue of outcomes still owed by the block.
    class slot_table_scoreboard;
        t_status          status_tab[NSLOT];
        logic [TGT_W-1:0] link_tab[NSLOT];
        bit               free_ok;
        logic [TGT_W-1:0] free_top;
        int unsigned      fresh_count;
        bit               run_ok;
        logic [TGT_W-1:0] run_slot;
        int unsigned      live_n;
        t_outcome         expected_q[$];
        int unsigned      fail_count;

        function new();
            foreach (status_tab[i]) begin
                status_tab[i] = ST_UNUSED;
                link_tab[i]   = '0;
            end
            free_ok     = 1'b0;
            free_top    = '0;
            fresh_count = 0;
            run_ok      = 1'b0;
            run_slot    = '0;
            live_n      = 0;
            fail_count  = 0;
        endfunction

        // Apply one accepted request to the model and queue its outcome.
        function void note_request(t_op op, logic [TGT_W-1:0] tgt);
            t_outcome res;
            res.ok   = 1'b0;
            res.slot = '0;
            case (op)
                OP_CREATE: begin
                    // Reuse the free-list head first, else take a fresh slot.
                    if (free_ok) begin
                        res.slot = free_top;
                        if (link_tab[free_top] == free_top) begin
                            free_ok = 1'b0;
                        end else begin
                            free_top = link_tab[free_top];
                        end
                        res.ok = 1'b1;
                    end else if (fresh_count < NSLOT) begin
                        res.slot = RES_SLOT_W'(fresh_count);
                        fresh_count++;
                        res.ok = 1'b1;
                    end
                    if (res.ok) begin
                        status_tab[res.slot] = ST_SUSPENDED;
                        link_tab[res.slot]   = res.slot;
                        live_n++;
                    end
                end
                OP_DONE: begin
                    // The current slot goes on top of the free list.
                    if (run_ok) begin
                        res.slot           = run_slot;
                        link_tab[run_slot] = free_ok ? free_top : run_slot;
                        status_tab[run_slot] = ST_DONE;
                        free_top = run_slot;
                        free_ok  = 1'b1;
                        run_ok   = 1'b0;
                        run_slot = '0;
                        if (live_n > 0) live_n--;
                        res.ok = 1'b1;
                    end
                end
                OP_YIELD: begin
                    if (run_ok) begin
                        res.slot             = run_slot;
                        status_tab[run_slot] = ST_SUSPENDED;
                        run_ok   = 1'b0;
                        run_slot = '0;
                        res.ok   = 1'b1;
                    end
                end
                default: begin
                    // A running slot that is replaced keeps its running status.
                    if (tgt < fresh_count && status_tab[tgt] == ST_SUSPENDED) begin
                        res.slot        = tgt;
                        status_tab[tgt] = ST_RUNNING;
                        run_slot = tgt;
                        run_ok   = 1'b1;
                        res.ok   = 1'b1;
                    end
                end
            endcase
            res.live   = LIVE_W'(live_n);
            expected_q = {expected_q, res};
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            fail_count++;
        endtask

        // Compare one accepted result with the oldest outcome owed.
        task check_result(logic ok, logic [RES_SLOT_W-1:0] slot, logic [LIVE_W-1:0] live);
            t_outcome want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with no request pending: ok=%0b slot=%0d live=%0d",
                                 ok, slot, live));
                return;
            end
            want = expected_q.pop_front();
            if (ok !== want.ok)
                report($sformatf("ok: got %0b, expected %0b", ok, want.ok));
            if (slot !== want.slot)
                report($sformatf("result_slot: got %0d, expected %0d", slot, want.slot));
            if (live !== want.live)
                report($sformatf("live_count: got %0d, expected %0d", live, want.live));
        endtask

        task check_leftovers();
            if (expected_q.size() != 0)
                report($sformatf("%0d results never arrived", expected_q.size()));
        endtask

        // A random suspended slot, or -1 when there is none.
        function int pick_suspended();
            int cands[$];
            foreach (status_tab[i]) begin
                if (i < fresh_count && status_tab[i] == ST_SUSPENDED) cands = {cands, i};
            end
            if (cands.size() == 0) return -1;
            return cands[$urandom_range(0, cands.size() - 1)];
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op;
    logic [TGT_W-1:0]      i_target_slot;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_ok;
    logic [RES_SLOT_W-1:0] o_result_slot;
    logic [LIVE_W-1:0]     o_live_count;

    slot_table_scoreboard sb;
    bit                   tx_idle;
    bit                   rx_idle;
    bit                   hold_req;
    int unsigned          create_pct;
    int unsigned          cycle_count;

    coroutine_slot_allocator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_target_slot (i_target_slot),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_result_slot (o_result_slot),
        .o_live_count  (o_live_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("coroutine_slot_allocator_top test failed");
            $finish;
        end
    end

    // Results are checked at the edge that accepts them.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_result(o_ok, o_result_slot, o_live_count);
    end

    // Result side: a random stall before each result when rx_idle is set, or one long hold when asked.
    initial begin : result_sink
        int unsigned hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold     = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                hold = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
            @(negedge i_clk);
        end
    end

    // Offer one request after a gap and hold it until the block takes it.
    task send_request(t_op op, logic [TGT_W-1:0] tgt, int unsigned gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_target_slot <= tgt;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(op, tgt);
        @(negedge i_clk);
    endtask

    // Stop offering requests until every owed result has come back.
    task drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    // Mostly well-formed lifecycles: create, resume, then yield or done; some noise.
    task random_request();
        t_op              op;
        logic [TGT_W-1:0] tgt;
        int               pick;
        int unsigned      roll;
        tgt  = TGT_W'($urandom_range(0, NSLOT - 1));
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            op = t_op'($urandom_range(0, 3));
        end else if (sb.run_ok) begin
            roll = $urandom_range(0, 99);
            op   = (roll < 45) ? OP_YIELD : (roll < 90) ? OP_DONE : OP_CREATE;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < create_pct) begin
                op = OP_CREATE;
            end else begin
                op   = OP_RESUME;
                pick = sb.pick_suspended();
                if (pick >= 0 && $urandom_range(0, 9) != 0) tgt = TGT_W'(pick);
            end
        end
        send_request(op, tgt, tx_idle ? $urandom_range(0, MAX_GAP) : 0);
    endtask

    initial begin : stimulus
        int unsigned phase;
        sb          = new();
        cycle_count = 0;
        tx_idle     = 1'b1;
        rx_idle     = 1'b1;
        hold_req    = 1'b0;
        create_pct  = 40;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_op          = OP_CREATE;
        i_target_slot = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Refusals on an empty table: resume out of range, done and yield with no current.
        send_request(OP_RESUME, 4'd15, 0);
        send_request(OP_DONE, 4'd0, 1);
        send_request(OP_YIELD, 4'd15, 0);
        // Fill every fresh slot, then one create past a full table.
        repeat (NSLOT + 1) send_request(OP_CREATE, TGT_W'($urandom_range(0, NSLOT - 1)),
                                        $urandom_range(0, 3));
        // Resume the top slot, resume it again while running, then retire and reuse it.
        send_request(OP_RESUME, 4'd15, 0);
        send_request(OP_RESUME, 4'd15, 0);
        send_request(OP_DONE, 4'd0, 2);
        send_request(OP_CREATE, 4'd0, 0);
        // Resume while another slot runs, then yield the new current slot.
        send_request(OP_RESUME, 4'd0, 0);
        send_request(OP_RESUME, 4'd1, 0);
        send_request(OP_YIELD, 4'd0, 0);
        drain_results();

        // Random phases with varied idling and create bias.
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            tx_idle    = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            rx_idle    = (phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            create_pct = $urandom_range(20, 65);
            if (phase == 2) begin
                // Long receiver hold while requests keep coming back to back.
                hold_req = 1'b1;
                tx_idle  = 1'b0;
            end
            repeat (PHASE_ITEMS) random_request();
            if (phase % 2 == 1) drain_results();
        end

        drain_results();
        repeat (8) @(negedge i_clk);
        sb.check_leftovers();
        if (sb.fail_count == 0) begin
            $display("coroutine_slot_allocator_top test passed");
        end else begin
            $display("coroutine_slot_allocator_top test failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/csa_pkg.sv
sv/csa_table.sv
sv/coroutine_slot_allocator_top.sv
tb/sv/tb_coroutine_slot_allocator_top.sv
